>>> sv/alignment_md_nm_generator_assert.svh
// assertion helpers for the md/nm generator
`ifndef ALIGNMENT_MD_NM_GENERATOR_ASSERT_SVH
`define ALIGNMENT_MD_NM_GENERATOR_ASSERT_SVH

// condition holds in the same cycle
`define AMNM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("amnm assertion failed");

// condition holds in the next cycle
`define AMNM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("amnm assertion failed");

`endif

>>> sv/amnm_pkg.sv
package amnm_pkg;

  // result count fields are clamped to this width
  localparam int OUT_BITS = 24;
  localparam int LEN_BITS = 28;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_IDX_BITS = 1;

  // nt16 code that never matches
  localparam logic [3:0] NT16_NONE = 4'hF;
  // query code that always matches
  localparam logic [3:0] NT16_EQ = 4'h0;

  typedef enum logic [2:0] {
    CMD_ALIGN = 3'd0,
    CMD_DEL   = 3'd1,
    CMD_INS   = 3'd2,
    CMD_SOFT  = 3'd3,
    CMD_SKIP  = 3'd4,
    CMD_END   = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    TK_NONE       = 3'd0,
    TK_CNT_BASE   = 3'd1,
    TK_CNT_DEL    = 3'd2,
    TK_BASE       = 3'd3,
    TK_FINAL      = 3'd4,
    TK_CNT_CARET  = 3'd5
  } tok_kind_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_EQ_REPLACE     = 1'd0,
    REG_MISMATCH_LIMIT = 1'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0]          cmd;
    logic [3:0]          query_base;
    logic [7:0]          ref_char;
    logic                in_bounds;
    logic                first_of_op;
    logic [LEN_BITS-1:0] run_length;
  } beat_t;

  // per-beat decisions handed to the counter logic
  typedef struct packed {
    tok_kind_t  kind;
    logic [7:0] token_char;
    logic [3:0] query_out;
    logic       end_rec;
    logic       clr_run;
    logic       inc_run;
    logic       inc_nm;
    logic       add_len;
    logic       set_stop;
    logic       cnt_new;
    logic       cnt_zero;
  } action_t;

  function automatic logic [7:0] upper_ascii(input logic [7:0] ch);
    logic [7:0] r;
    r = ch;
    if (ch inside {[8'h61:8'h7A]}) begin
      r = ch - 8'd32;
    end
    return r;
  endfunction

  function automatic logic [3:0] nt16_code(input logic [7:0] ch);
    logic [3:0] c;
    case (upper_ascii(ch))
      "=":      c = 4'd0;
      "A":      c = 4'd1;
      "C":      c = 4'd2;
      "M":      c = 4'd3;
      "G":      c = 4'd4;
      "R":      c = 4'd5;
      "S":      c = 4'd6;
      "V":      c = 4'd7;
      "T", "U": c = 4'd8;
      "W":      c = 4'd9;
      "Y":      c = 4'd10;
      "H":      c = 4'd11;
      "K":      c = 4'd12;
      "D":      c = 4'd13;
      "B":      c = 4'd14;
      default:  c = NT16_NONE;
    endcase
    return c;
  endfunction

endpackage

>>> sv/amnm_if.sv
// input channel: one alignment column or cigar event per beat
interface amnm_in_if
  import amnm_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [2:0]          cmd;
  logic [3:0]          query_base;
  logic [7:0]          ref_char;
  logic                in_bounds;
  logic                first_of_op;
  logic [LEN_BITS-1:0] run_length;

  modport source (output valid, cmd, query_base, ref_char, in_bounds, first_of_op,
                  run_length, input ready);
  modport sink (input valid, cmd, query_base, ref_char, in_bounds, first_of_op,
                run_length, output ready);
endinterface

// result channel: one md token description per beat
interface amnm_out_if
  import amnm_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [2:0]          token_kind;
  logic [OUT_BITS-1:0] run_count;
  logic [7:0]          token_char;
  logic [3:0]          query_base_out;
  logic [OUT_BITS-1:0] edit_distance;
  logic                over_limit;

  modport source (output valid, token_kind, run_count, token_char, query_base_out,
                  edit_distance, over_limit, input ready);
  modport sink (input valid, token_kind, run_count, token_char, query_base_out,
                edit_distance, over_limit, output ready);
endinterface

>>> sv/amnm_classify.sv
module amnm_classify
  import amnm_pkg::*;
(
  input  beat_t   beat,
  input  logic    stopped,
  input  logic    eq_replace,
  output action_t act
);

  logic       col_ok;
  logic       is_match;
  logic [3:0] ref_code;

  // column is usable when in bounds and reference base present
  assign col_ok   = beat.in_bounds && (beat.ref_char != 8'd0);
  assign ref_code = nt16_code(beat.ref_char);
  assign is_match = ((beat.query_base == ref_code) && (beat.query_base != NT16_NONE))
                    || (beat.query_base == NT16_EQ);

  // decide token and counter updates
  always_comb begin
    act = '0;
    act.kind = TK_NONE;
    if (beat.cmd == CMD_ALIGN) begin
      act.query_out = beat.query_base;
    end
    case (beat.cmd)
      CMD_END: begin
        act.kind    = TK_FINAL;
        act.end_rec = 1'b1;
      end
      CMD_ALIGN: begin
        if (!stopped) begin
          if (!col_ok) begin
            act.set_stop = 1'b1;
          end else if (is_match) begin
            act.inc_run = 1'b1;
            act.cnt_new = 1'b1;
            if (eq_replace) begin
              act.query_out = NT16_EQ;
            end
          end else begin
            act.kind       = TK_CNT_BASE;
            act.token_char = upper_ascii(beat.ref_char);
            act.clr_run    = 1'b1;
            act.inc_nm     = 1'b1;
          end
        end
      end
      CMD_DEL: begin
        if (!stopped) begin
          if (beat.first_of_op) begin
            act.clr_run = 1'b1;
            if (col_ok) begin
              act.kind       = TK_CNT_DEL;
              act.token_char = upper_ascii(beat.ref_char);
              act.inc_nm     = 1'b1;
            end else begin
              act.kind     = TK_CNT_CARET;
              act.set_stop = 1'b1;
            end
          end else if (col_ok) begin
            act.kind       = TK_BASE;
            act.cnt_zero   = 1'b1;
            act.token_char = upper_ascii(beat.ref_char);
            act.inc_nm     = 1'b1;
          end else begin
            act.set_stop = 1'b1;
          end
        end
      end
      CMD_INS: begin
        act.add_len = !stopped;
      end
      default: begin
        act.kind = TK_NONE;
      end
    endcase
  end

endmodule

>>> sv/alignment_md_nm_generator.sv
// MD tag and NM edit-distance generator.
// in_ch carries one alignment column or cigar event per beat; out_ch returns
// exactly one token description per input beat, in order.
// cfg_we/cfg_index/cfg_data write the equal-replacement enable (index 0) and
// mismatch_limit (index 1); write them only while no beat is in flight.
// Each result is registered and shown in the cycle after its input beat is accepted.
// Throughput: one beat per cycle while out_ch is not stalled. The match-run and
// NM counters update with the beat, so the next column sees the new counts at once.
// Stall: the result register holds its beat while out_ch.ready is low; a new
// beat is taken in any cycle where the result register is empty or drains.
// Reset (synchronous, rst_n low): counters, stopped flag, configuration and
// the result valid are cleared; a beat accepted during reset is dropped, not shown.
// The end-of-record beat gives the final count and NM, raises over_limit when
// the enabled limit is reached, and clears the record state.
module alignment_md_nm_generator
  import amnm_pkg::*;
#(
  parameter int COUNT_BITS = 24
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  amnm_in_if.sink                  in_ch,
  amnm_out_if.source               out_ch
);

  localparam int SUM_W = ((COUNT_BITS > LEN_BITS) ? COUNT_BITS : LEN_BITS) + 1;
  localparam logic [SUM_W-1:0] CNT_MAX_W = SUM_W'((64'd1 << COUNT_BITS) - 64'd1);

  logic                     eq_replace_r;
  logic [CFG_DATA_BITS-1:0] limit_r;
  logic [COUNT_BITS-1:0]    run_r, run_nxt;
  logic [COUNT_BITS-1:0]    nm_r, nm_nxt;
  logic                     stopped_r, stopped_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     acc_in;
  beat_t                    beat;
  action_t                  act;

  logic [SUM_W-1:0]         nm_addend;
  logic [SUM_W-1:0]         nm_sum;
  logic [COUNT_BITS-1:0]    nm_sat;
  logic [COUNT_BITS-1:0]    run_inc;
  logic [COUNT_BITS-1:0]    cnt_src;
  logic [COUNT_BITS-1:0]    ed_src;
  logic [OUT_BITS-1:0]      cnt_clamp;
  logic [OUT_BITS-1:0]      ed_clamp;
  logic                     over;

  tok_kind_t                kind_r;
  logic [OUT_BITS-1:0]      run_count_r;
  logic [7:0]               token_char_r;
  logic [3:0]               query_out_r;
  logic [OUT_BITS-1:0]      edit_r;
  logic                     over_r;

  // handshake
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign acc_in      = in_ch.valid && in_ch.ready;

  assign beat.cmd         = in_ch.cmd;
  assign beat.query_base  = in_ch.query_base;
  assign beat.ref_char    = in_ch.ref_char;
  assign beat.in_bounds   = in_ch.in_bounds;
  assign beat.first_of_op = in_ch.first_of_op;
  assign beat.run_length  = in_ch.run_length;

  amnm_classify u_classify (
    .beat       (beat),
    .stopped    (stopped_r),
    .eq_replace (eq_replace_r),
    .act        (act)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eq_replace_r <= 1'b0;
      limit_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EQ_REPLACE:     eq_replace_r <= cfg_data[0];
        REG_MISMATCH_LIMIT: limit_r      <= cfg_data;
        default:            eq_replace_r <= eq_replace_r;
      endcase
    end
  end

  // saturating edit distance: one adder for single edits and insertion runs
  assign nm_addend = act.add_len ? SUM_W'(beat.run_length) : SUM_W'(1);
  assign nm_sum    = SUM_W'(nm_r) + nm_addend;
  assign nm_sat    = (nm_sum > CNT_MAX_W) ? COUNT_BITS'(CNT_MAX_W) : nm_sum[COUNT_BITS-1:0];
  assign run_inc   = (&run_r) ? run_r : run_r + COUNT_BITS'(1);

  // next record state
  always_comb begin
    run_nxt     = run_r;
    nm_nxt      = nm_r;
    stopped_nxt = stopped_r;
    if (act.end_rec) begin
      run_nxt     = '0;
      nm_nxt      = '0;
      stopped_nxt = 1'b0;
    end else begin
      if (act.clr_run) begin
        run_nxt = '0;
      end else if (act.inc_run) begin
        run_nxt = run_inc;
      end
      if (act.inc_nm || act.add_len) begin
        nm_nxt = nm_sat;
      end
      if (act.set_stop) begin
        stopped_nxt = 1'b1;
      end
    end
  end

  // result fields before clamping
  assign cnt_src = act.cnt_zero ? '0 : (act.cnt_new ? run_nxt : run_r);
  assign ed_src  = act.end_rec ? nm_r : nm_nxt;
  assign over    = act.end_rec && (limit_r != '0) &&
                   (nm_r >= COUNT_BITS'(limit_r));

  // clamp counts onto the result width
  generate
    if (COUNT_BITS > OUT_BITS) begin : g_clamp
      assign cnt_clamp = (|cnt_src[COUNT_BITS-1:OUT_BITS]) ? '1 : cnt_src[OUT_BITS-1:0];
      assign ed_clamp  = (|ed_src[COUNT_BITS-1:OUT_BITS]) ? '1 : ed_src[OUT_BITS-1:0];
    end else begin : g_pass
      assign cnt_clamp = OUT_BITS'(cnt_src);
      assign ed_clamp  = OUT_BITS'(ed_src);
    end
  endgenerate

  // record state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r     <= '0;
      nm_r      <= '0;
      stopped_r <= 1'b0;
    end else if (acc_in) begin
      run_r     <= run_nxt;
      nm_r      <= nm_nxt;
      stopped_r <= stopped_nxt;
    end
  end

  // result register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (acc_in) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, loaded with each accepted beat
  always_ff @(posedge clk) begin
    if (acc_in) begin
      kind_r       <= act.kind;
      run_count_r  <= cnt_clamp;
      token_char_r <= act.token_char;
      query_out_r  <= act.query_out;
      edit_r       <= ed_clamp;
      over_r       <= over;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.token_kind     = kind_r;
  assign out_ch.run_count      = run_count_r;
  assign out_ch.token_char     = token_char_r;
  assign out_ch.query_base_out = query_out_r;
  assign out_ch.edit_distance  = edit_r;
  assign out_ch.over_limit     = over_r;

  `include "alignment_md_nm_generator_assert.svh"

  `AMNM_ASSERT_NEXT(a_end_clears, acc_in && act.end_rec, run_r == '0 && nm_r == '0 && !stopped_r)
  `AMNM_ASSERT_NEXT(a_nm_monotonic, acc_in && !act.end_rec, nm_r >= $past(nm_r))
  `AMNM_ASSERT_NOW(a_stopped_silent, acc_in && stopped_r, act.kind == TK_NONE || act.kind == TK_FINAL)
  `AMNM_ASSERT_NOW(a_over_only_final, out_valid_r && over_r, kind_r == TK_FINAL)

endmodule

>>> sim/alignment_md_nm_generator_tb.sv
module alignment_md_nm_generator_tb
  import amnm_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CNT_W = 24;
  localparam longint unsigned OUT_MAX = (64'd1 << OUT_BITS) - 1;

  // one md token as seen on the result channel
  typedef struct packed {
    logic [2:0]          kind;
    logic [OUT_BITS-1:0] count;
    logic [7:0]          ch;
    logic [3:0]          qout;
    logic [OUT_BITS-1:0] nm;
    logic                over;
  } md_token_t;

  // md/nm predictor with its own record state and token queue
  class md_scoreboard;
    bit                use_eq;
    logic [15:0]       nm_limit;
    logic [CNT_W-1:0]  run_ctr;
    logic [CNT_W-1:0]  nm_ctr;
    bit                stopped;
    md_token_t         expected_q[$];
    int                errors;

    function new();
      use_eq = 1'b0;
      nm_limit = '0;
      run_ctr = '0;
      nm_ctr = '0;
      stopped = 1'b0;
      errors = 0;
    endfunction

    static function logic [7:0] to_upper(logic [7:0] ch);
      return (ch >= "a" && ch <= "z") ? ch - 8'd32 : ch;
    endfunction

    // nt16 code: position in the iupac string, u folds onto t
    static function logic [3:0] code_of(logic [7:0] ch);
      string iupac;
      logic [7:0] up;
      iupac = "=ACMGRSVTWYHKDB";
      up = to_upper(ch);
      if (up == "U") return 4'd8;
      for (int i = 0; i < 15; i++) begin
        if (iupac[i] == up) return 4'(i);
      end
      return NT16_NONE;
    endfunction

    function logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] a, logic [LEN_BITS-1:0] b);
      logic [CNT_W+LEN_BITS:0] s;
      s = a + b;
      if (s[CNT_W+LEN_BITS:CNT_W] != 0) return '1;
      return s[CNT_W-1:0];
    endfunction

    function logic [OUT_BITS-1:0] clamp(logic [CNT_W-1:0] v);
      longint unsigned w;
      w = v;
      return (w > OUT_MAX) ? '1 : w[OUT_BITS-1:0];
    endfunction

    function md_token_t predict(beat_t b);
      md_token_t t;
      logic good;
      logic hit;
      t = '0;
      t.kind = TK_NONE;
      t.count = clamp(run_ctr);
      good = b.in_bounds && (b.ref_char != 8'd0);
      // end of record reports and clears
      if (b.cmd == CMD_END) begin
        t.kind = TK_FINAL;
        t.nm = clamp(nm_ctr);
        t.over = (nm_limit != 0) && (nm_ctr >= nm_limit);
        run_ctr = '0;
        nm_ctr = '0;
        stopped = 1'b0;
        return t;
      end
      if (b.cmd == CMD_ALIGN) t.qout = b.query_base;
      if (!stopped) begin
        case (b.cmd)
          CMD_ALIGN: begin
            if (!good) begin
              stopped = 1'b1;
            end else begin
              hit = (b.query_base == NT16_EQ) ||
                    (b.query_base == code_of(b.ref_char) && b.query_base != NT16_NONE);
              if (hit) begin
                if (use_eq) t.qout = 4'd0;
                run_ctr = sat_add(run_ctr, LEN_BITS'(1));
                t.count = clamp(run_ctr);
              end else begin
                t.kind = TK_CNT_BASE;
                t.ch = to_upper(b.ref_char);
                run_ctr = '0;
                nm_ctr = sat_add(nm_ctr, LEN_BITS'(1));
              end
            end
          end
          CMD_DEL: begin
            if (b.first_of_op) begin
              run_ctr = '0;
              if (good) begin
                t.kind = TK_CNT_DEL;
                t.ch = to_upper(b.ref_char);
                nm_ctr = sat_add(nm_ctr, LEN_BITS'(1));
              end else begin
                t.kind = TK_CNT_CARET;
                stopped = 1'b1;
              end
            end else if (good) begin
              // later deleted bases carry no count
              t.kind = TK_BASE;
              t.count = '0;
              t.ch = to_upper(b.ref_char);
              nm_ctr = sat_add(nm_ctr, LEN_BITS'(1));
            end else begin
              stopped = 1'b1;
            end
          end
          CMD_INS: nm_ctr = sat_add(nm_ctr, b.run_length);
          default: ;
        endcase
      end
      t.nm = clamp(nm_ctr);
      return t;
    endfunction

    function void note_column(beat_t b);
      expected_q.push_back(predict(b));
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_token(md_token_t got);
      md_token_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: token with no column pending, expected none actual kind %0d",
                 $time, got.kind);
        return;
      end
      want = expected_q.pop_front();
      compare_field("token_kind", 32'(want.kind), 32'(got.kind));
      compare_field("run_count", 32'(want.count), 32'(got.count));
      compare_field("token_char", 32'(want.ch), 32'(got.ch));
      compare_field("query_base_out", 32'(want.qout), 32'(got.qout));
      compare_field("edit_distance", 32'(want.nm), 32'(got.nm));
      compare_field("over_limit", 32'(want.over), 32'(got.over));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  amnm_in_if  in_ch ();
  amnm_out_if out_ch ();

  md_scoreboard sb;
  bit tx_idle;
  bit rx_idle;
  int rx_hold_cycles;
  int columns_sent;

  alignment_md_nm_generator #(.COUNT_BITS(CNT_W)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #2 clk = ~clk;

  // run limit
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  // one column beat, with an optional gap before it
  task automatic send_column(input beat_t b);
    int gap;
    gap = tx_idle ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= b.cmd;
    in_ch.query_base  <= b.query_base;
    in_ch.ref_char    <= b.ref_char;
    in_ch.in_bounds   <= b.in_bounds;
    in_ch.first_of_op <= b.first_of_op;
    in_ch.run_length  <= b.run_length;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    sb.note_column(b);
    columns_sent++;
  endtask

  // stop offering and wait for every token to come back
  task automatic drain_tokens();
    in_ch.valid <= 1'b0;
    for (int i = 0; i < 5000 && sb.pending() != 0; i++) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic program_regs(input bit ue, input logic [15:0] lim);
    cfg_we    <= 1'b1;
    cfg_index <= REG_EQ_REPLACE;
    cfg_data  <= CFG_DATA_BITS'(ue);
    @(posedge clk);
    cfg_index <= REG_MISMATCH_LIMIT;
    cfg_data  <= lim;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.use_eq = ue;
    sb.nm_limit = lim;
  endtask

  function automatic beat_t col(cmd_t c, logic [3:0] q, logic [7:0] r, logic inb,
                                logic first, logic [LEN_BITS-1:0] len);
    beat_t b;
    b.cmd = c;
    b.query_base = q;
    b.ref_char = r;
    b.in_bounds = inb;
    b.first_of_op = first;
    b.run_length = len;
    return b;
  endfunction

  function automatic logic [7:0] pick_ref_char();
    string pool;
    pool = "ACGTacgtNn=MRSWYKVHDBUu*";
    if ($urandom_range(0, 19) == 0) return 8'($urandom());
    return pool[$urandom_range(0, pool.len() - 1)];
  endfunction

  // fields that the command ignores still get random values
  function automatic beat_t rand_fill();
    beat_t b;
    b.cmd = 3'($urandom_range(0, 5));
    b.query_base = 4'($urandom());
    b.ref_char = 8'($urandom());
    b.in_bounds = 1'($urandom());
    b.first_of_op = 1'($urandom());
    b.run_length = LEN_BITS'($urandom());
    return b;
  endfunction

  function automatic beat_t rand_aligned();
    beat_t b;
    b = rand_fill();
    b.cmd = CMD_ALIGN;
    b.ref_char = pick_ref_char();
    if ($urandom_range(0, 9) < 7) b.query_base = md_scoreboard::code_of(b.ref_char);
    b.in_bounds = ($urandom_range(0, 49) != 0);
    if ($urandom_range(0, 99) == 0) b.ref_char = 8'd0;
    return b;
  endfunction

  function automatic beat_t rand_deleted(logic first);
    beat_t b;
    b = rand_fill();
    b.cmd = CMD_DEL;
    b.first_of_op = first;
    b.ref_char = pick_ref_char();
    b.in_bounds = ($urandom_range(0, 29) != 0);
    if ($urandom_range(0, 99) == 0) b.ref_char = 8'd0;
    return b;
  endfunction

  function automatic beat_t rand_event();
    beat_t b;
    int sel;
    b = rand_fill();
    sel = $urandom_range(0, 2);
    b.cmd = (sel == 0) ? CMD_INS : (sel == 1) ? CMD_SOFT : CMD_SKIP;
    sel = $urandom_range(0, 99);
    if (sel < 85) b.run_length = LEN_BITS'($urandom_range(0, 20));
    else if (sel < 97) b.run_length = LEN_BITS'($urandom());
    else b.run_length = '1;
    return b;
  endfunction

  // mostly well-formed records, some noise and broken runs mixed in
  task automatic send_record();
    int n;
    int pick;
    int k;
    n = $urandom_range(1, 24);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        send_column(rand_aligned());
      end else if (pick < 72) begin
        k = $urandom_range(0, 4);
        send_column(rand_deleted(1'b1));
        for (int j = 0; j < k; j++) send_column(rand_deleted(1'b0));
      end else if (pick < 92) begin
        send_column(rand_event());
      end else begin
        send_column(rand_fill());
      end
    end
    if ($urandom_range(0, 19) != 0)
      send_column(col(CMD_END, 4'($urandom()), 8'($urandom()), 1'($urandom()),
                      1'($urandom()), LEN_BITS'($urandom())));
  endtask

  // result side: random stalls, plus a long hold-off on request
  initial begin
    int gap;
    md_token_t got;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        gap = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        gap = rx_idle ? $urandom_range(0, 8) : 0;
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (out_ch.valid !== 1'b1) @(posedge clk);
      got.kind  = out_ch.token_kind;
      got.count = out_ch.run_count;
      got.ch    = out_ch.token_char;
      got.qout  = out_ch.query_base_out;
      got.nm    = out_ch.edit_distance;
      got.over  = out_ch.over_limit;
      sb.check_token(got);
    end
  end

  // main sequence
  initial begin
    int target;
    sb = new();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    rx_hold_cycles = 0;
    columns_sent = 0;
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= REG_EQ_REPLACE;
    cfg_data          <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.cmd         <= CMD_ALIGN;
    in_ch.query_base  <= '0;
    in_ch.ref_char    <= '0;
    in_ch.in_bounds   <= 1'b0;
    in_ch.first_of_op <= 1'b0;
    in_ch.run_length  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // matches, query zero, code fifteen, u as t, '=' reference, deletions
    send_column(col(CMD_ALIGN, 4'd1, "A", 1'b1, 1'b0, '0));
    send_column(col(CMD_ALIGN, 4'd2, "c", 1'b1, 1'b0, '0));
    send_column(col(CMD_ALIGN, NT16_EQ, "N", 1'b1, 1'b0, '0));
    send_column(col(CMD_ALIGN, NT16_NONE, "N", 1'b1, 1'b0, '0));
    send_column(col(CMD_ALIGN, 4'd8, "u", 1'b1, 1'b0, '0));
    send_column(col(CMD_ALIGN, 4'd4, "=", 1'b1, 1'b0, '0));
    send_column(col(CMD_DEL, 4'd0, "a", 1'b1, 1'b1, '0));
    send_column(col(CMD_DEL, 4'd0, "t", 1'b1, 1'b0, '0));
    // nm saturates on a maximal insertion
    send_column(col(CMD_INS, 4'd0, 8'd0, 1'b1, 1'b0, '1));
    send_column(col(CMD_SOFT, 4'hF, 8'hFF, 1'b1, 1'b1, '1));
    send_column(col(CMD_SKIP, 4'd0, "G", 1'b0, 1'b0, LEN_BITS'(12)));
    send_column(col(CMD_ALIGN, 4'hF, 8'hFF, 1'b1, 1'b1, '1));
    send_column(col(CMD_END, 4'd0, 8'd0, 1'b1, 1'b0, '0));
    // out of bounds first deletion, then a stopped record
    send_column(col(CMD_ALIGN, 4'd1, "A", 1'b1, 1'b0, '0));
    send_column(col(CMD_DEL, 4'd0, "g", 1'b0, 1'b1, '0));
    send_column(col(CMD_ALIGN, 4'd3, "m", 1'b1, 1'b0, '0));
    send_column(col(CMD_DEL, 4'd0, "c", 1'b1, 1'b1, '0));
    send_column(col(CMD_END, 4'd0, 8'd0, 1'b1, 1'b0, '0));
    // zero reference char, out of bounds later deleted base
    send_column(col(CMD_ALIGN, 4'd2, 8'd0, 1'b1, 1'b0, '0));
    send_column(col(CMD_END, 4'd0, 8'd0, 1'b1, 1'b0, '0));
    send_column(col(CMD_DEL, 4'd0, "T", 1'b0, 1'b0, '0));
    send_column(col(CMD_END, 4'd0, 8'd0, 1'b1, 1'b0, '0));
    drain_tokens();

    // equal replacement and the limit flag
    program_regs(1'b1, 16'd2);
    send_column(col(CMD_ALIGN, 4'd1, "a", 1'b1, 1'b0, '0));
    send_column(col(CMD_ALIGN, 4'd2, "g", 1'b1, 1'b0, '0));
    send_column(col(CMD_INS, 4'd0, 8'd0, 1'b1, 1'b0, LEN_BITS'(1)));
    send_column(col(CMD_END, 4'd0, 8'd0, 1'b1, 1'b0, '0));
    send_column(col(CMD_ALIGN, 4'd4, "G", 1'b1, 1'b0, '0));
    send_column(col(CMD_END, 4'd0, 8'd0, 1'b1, 1'b0, '0));

    // random records under several settings
    for (int p = 0; p < 6; p++) begin
      drain_tokens();
      case (p)
        0: program_regs(1'b0, 16'd0);
        1: program_regs(1'b1, 16'd1);
        2: program_regs(1'b0, 16'hFFFF);
        3: program_regs(1'b1, 16'($urandom_range(2, 12)));
        4: program_regs(1'b0, 16'($urandom_range(1, 65535)));
        default: program_regs(1'b1, 16'd0);
      endcase
      case (p)
        0: begin
          tx_idle = 1'b1;
          rx_idle = 1'b1;
        end
        1: begin
          tx_idle = 1'b0;
          rx_idle = 1'b0;
        end
        2: begin
          tx_idle = 1'b0;
          rx_idle = 1'b1;
          rx_hold_cycles = 60;
        end
        default: begin
          tx_idle = 1'($urandom());
          rx_idle = 1'($urandom());
        end
      endcase
      target = columns_sent + 80;
      while (columns_sent < target) send_record();
    end

    drain_tokens();
    if (sb.pending() != 0) begin
      sb.errors++;
      $display("%0t: tokens missing, expected %0d more actual 0", $time, sb.pending());
    end
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
